// File: rtl/core/cao_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cursor alpha overlay core.
// No dependencies; used by the interfaces and every core module.
package cao_pkg;

    localparam int unsigned COORD_W    = 16;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned HOT_W      = 8;
    localparam int unsigned SIZE_W     = 9;
    localparam int unsigned TEXEL_W    = 32;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Item opcodes carried in the mode field; the fourth code is unused.
    typedef enum logic [MODE_W-1:0] {
        MODE_COLOR = 2'd0,
        MODE_MONO  = 2'd1,
        MODE_BLEND = 2'd2
    } t_mode;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINTER_X    = 3'd0,
        REG_POINTER_Y    = 3'd1,
        REG_HOTSPOT_X    = 3'd2,
        REG_HOTSPOT_Y    = 3'd3,
        REG_SHAPE_WIDTH  = 3'd4,
        REG_SHAPE_HEIGHT = 3'd5,
        REG_FRAME_WIDTH  = 3'd6,
        REG_FRAME_HEIGHT = 3'd7
    } t_cfg_idx;

    // Monochrome texel encodings: alpha in the top byte, then R, G, B.
    localparam logic [TEXEL_W-1:0] TEXEL_CLEAR = 32'h0000_0000;
    localparam logic [TEXEL_W-1:0] TEXEL_WHITE = 32'hFFFF_FFFF;
    localparam logic [TEXEL_W-1:0] TEXEL_BLACK = 32'hFF00_0000;

    localparam logic [SIZE_W-1:0] SHAPE_RESET = 9'd1;

    // Configuration register file as seen by the window logic.
    typedef struct packed {
        logic [COORD_W-1:0] pointer_x;
        logic [COORD_W-1:0] pointer_y;
        logic [HOT_W-1:0]   hotspot_x;
        logic [HOT_W-1:0]   hotspot_y;
        logic [SIZE_W-1:0]  shape_width;
        logic [SIZE_W-1:0]  shape_height;
        logic [COORD_W-1:0] frame_width;
        logic [COORD_W-1:0] frame_height;
    } t_cfg;

endpackage

// File: rtl/core/cao_if.sv
`timescale 1ns / 1ps
// Handshake channel interfaces of the cursor alpha overlay core.
// Depends on cao_pkg for field widths.
interface cao_pix_if;
    logic                             valid;
    logic                             ready;
    logic [cao_pkg::MODE_W-1:0]       mode;
    logic [cao_pkg::COORD_W-1:0]      pos_x;
    logic [cao_pkg::COORD_W-1:0]      pos_y;
    logic [cao_pkg::CHAN_W-1:0]       red;
    logic [cao_pkg::CHAN_W-1:0]       green;
    logic [cao_pkg::CHAN_W-1:0]       blue;
    logic [cao_pkg::CHAN_W-1:0]       alpha;
    logic                             and_bit;
    logic                             xor_bit;

    modport source (output valid, mode, pos_x, pos_y, red, green, blue, alpha,
                    and_bit, xor_bit, input ready);
    modport sink   (input valid, mode, pos_x, pos_y, red, green, blue, alpha,
                    and_bit, xor_bit, output ready);
endinterface

interface cao_res_if;
    logic                        valid;
    logic                        ready;
    logic [cao_pkg::CHAN_W-1:0]  out_red;
    logic [cao_pkg::CHAN_W-1:0]  out_green;
    logic [cao_pkg::CHAN_W-1:0]  out_blue;
    logic                        covered;

    modport source (output valid, out_red, out_green, out_blue, covered, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, covered, output ready);
endinterface

interface cao_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cao_pkg::CFG_IDX_W-1:0]   index;
    logic [cao_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/cao_image_store.sv
`timescale 1ns / 1ps
// Cursor image memory: one write port, one read port, registered read data.
// Depends on cao_pkg for the texel width.
module cao_image_store #(
    parameter int unsigned ADDR_W = 16
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ADDR_W-1:0]            i_waddr,
    input  logic [cao_pkg::TEXEL_W-1:0]  i_wdata,
    input  logic                         i_re,
    input  logic [ADDR_W-1:0]            i_raddr,
    output logic [cao_pkg::TEXEL_W-1:0]  o_rdata
);

    localparam int unsigned DEPTH = 1 << ADDR_W;

    logic [cao_pkg::TEXEL_W-1:0] r_mem [DEPTH];
    logic [cao_pkg::TEXEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while the reader stalls
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/cao_window.sv
`timescale 1ns / 1ps
// Cursor window geometry: clamps size and hotspot, tests a screen pixel
// against frame and window, forms the texel address. Depends on cao_pkg.
module cao_window #(
    parameter int unsigned MAX_CURSOR_SIZE = 256,
    parameter int unsigned AW              = 8
) (
    input  cao_pkg::t_cfg                i_cfg,
    input  logic                         i_loaded,
    input  logic [cao_pkg::COORD_W-1:0]  i_pos_x,
    input  logic [cao_pkg::COORD_W-1:0]  i_pos_y,
    output logic                         o_covered,
    output logic [2*AW-1:0]              o_addr
);

    localparam int unsigned        SW     = cao_pkg::SIZE_W;
    localparam int unsigned        DW     = cao_pkg::COORD_W + 2;
    localparam logic [SW-1:0]      MAX_SZ = SW'(MAX_CURSOR_SIZE);

    logic [SW-1:0] w, h, hx, hy;
    logic [DW-1:0] dx, dy;
    logic          in_x, in_y, in_frame;

    always_comb begin
        // size outside 1..MAX is pulled to the nearest limit
        if (i_cfg.shape_width == '0)         w = SW'(1);
        else if (i_cfg.shape_width > MAX_SZ) w = MAX_SZ;
        else                                 w = i_cfg.shape_width;
        if (i_cfg.shape_height == '0)         h = SW'(1);
        else if (i_cfg.shape_height > MAX_SZ) h = MAX_SZ;
        else                                  h = i_cfg.shape_height;

        // a hotspot strictly beyond the size drops to size-1
        hx = ({1'b0, i_cfg.hotspot_x} > w) ? w - SW'(1) : {1'b0, i_cfg.hotspot_x};
        hy = ({1'b0, i_cfg.hotspot_y} > h) ? h - SW'(1) : {1'b0, i_cfg.hotspot_y};

        // offset into the window, two's complement over DW bits
        dx = {2'b00, i_pos_x} - {2'b00, i_cfg.pointer_x} + DW'(hx);
        dy = {2'b00, i_pos_y} - {2'b00, i_cfg.pointer_y} + DW'(hy);

        in_x     = !dx[DW-1] && (dx[DW-2:0] < (DW-1)'(w));
        in_y     = !dy[DW-1] && (dy[DW-2:0] < (DW-1)'(h));
        in_frame = (i_pos_x < i_cfg.frame_width) && (i_pos_y < i_cfg.frame_height);

        o_covered = i_loaded && in_frame && in_x && in_y;
        o_addr    = {dy[AW-1:0], dx[AW-1:0]};
    end

endmodule

// File: rtl/core/cao_blend.sv
`timescale 1ns / 1ps
// Per-channel alpha blend of a cursor texel over a screen pixel.
// Depends on cao_pkg for channel and texel widths.
module cao_blend (
    input  logic [cao_pkg::TEXEL_W-1:0]  i_texel,
    input  logic                         i_covered,
    input  logic [cao_pkg::CHAN_W-1:0]   i_red,
    input  logic [cao_pkg::CHAN_W-1:0]   i_green,
    input  logic [cao_pkg::CHAN_W-1:0]   i_blue,
    output logic [cao_pkg::CHAN_W-1:0]   o_red,
    output logic [cao_pkg::CHAN_W-1:0]   o_green,
    output logic [cao_pkg::CHAN_W-1:0]   o_blue
);

    localparam int unsigned CW = cao_pkg::CHAN_W;
    localparam int unsigned PW = 2 * CW + 1;

    // (old*(256-a) + new*a) >> 8; the sum never exceeds 16 bits
    function automatic logic [CW-1:0] mix(input logic [CW-1:0] old_c,
                                          input logic [CW-1:0] new_c,
                                          input logic [CW-1:0] a);
        logic [CW:0]   inv_a;
        logic [PW-1:0] sum;
        inv_a = (CW+1)'(1 << CW) - {1'b0, a};
        sum   = PW'(old_c) * PW'(inv_a) + PW'(new_c) * PW'(a);
        return sum[2*CW-1:CW];
    endfunction

    logic [CW-1:0] ta, tr, tg, tb;

    always_comb begin
        ta = i_texel[4*CW-1:3*CW];
        tr = i_texel[3*CW-1:2*CW];
        tg = i_texel[2*CW-1:CW];
        tb = i_texel[CW-1:0];
        if (i_covered) begin
            o_red   = mix(i_red, tr, ta);
            o_green = mix(i_green, tg, ta);
            o_blue  = mix(i_blue, tb, ta);
        end else begin
            o_red   = i_red;
            o_green = i_green;
            o_blue  = i_blue;
        end
    end

endmodule

// File: rtl/core/cursor_alpha_overlay_core.sv
`timescale 1ns / 1ps
// Top level of the cursor alpha overlay: config registers, pipeline control.
// Depends on cao_pkg, cao_if, cao_image_store, cao_window and cao_blend.
//
//  channel  | dir | modport | carries
//  ---------+-----+---------+------------------------------------------------
//  i_pix    | in  | sink    | texel write or screen pixel: mode, pos, rgb, a
//  o_res    | out | source  | blended pixel: out_red/green/blue, covered
//  i_cfg    | in  | sink    | register write: index 0..7, data (always ready)
//
// One request per clock while i_pix.ready is high. A blend request goes to o_res
// in steps: accept and image read issue, then blend from the registered read
// data into the output register. Texel writes land in the image memory at the
// accept edge and produce no result. The image memory (MAX_CURSOR_SIZE squared
// texels) has no reset and needs no clearing pass; reset clears the registers
// and the loaded flag. A stalled o_res holds the output register; the blend
// stage behind it still takes one more request, then i_pix.ready drops.
module cursor_alpha_overlay_core #(
    parameter int unsigned MAX_CURSOR_SIZE = 256
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cao_pix_if.sink   i_pix,
    cao_res_if.source o_res,
    cao_cfg_if.sink   i_cfg
);

    localparam int unsigned AW = $clog2(MAX_CURSOR_SIZE);
    localparam int unsigned CW = cao_pkg::CHAN_W;
    localparam logic [cao_pkg::COORD_W:0] MAX_POS = (cao_pkg::COORD_W+1)'(MAX_CURSOR_SIZE);

    // ---------------------------------------------------------------- config
    cao_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg              <= '0;
            r_cfg.shape_width  <= cao_pkg::SHAPE_RESET;
            r_cfg.shape_height <= cao_pkg::SHAPE_RESET;
        end else if (i_cfg.valid) begin
            unique case (cao_pkg::t_cfg_idx'(i_cfg.index))
                cao_pkg::REG_POINTER_X:    r_cfg.pointer_x    <= i_cfg.data;
                cao_pkg::REG_POINTER_Y:    r_cfg.pointer_y    <= i_cfg.data;
                cao_pkg::REG_HOTSPOT_X:    r_cfg.hotspot_x    <= i_cfg.data[cao_pkg::HOT_W-1:0];
                cao_pkg::REG_HOTSPOT_Y:    r_cfg.hotspot_y    <= i_cfg.data[cao_pkg::HOT_W-1:0];
                cao_pkg::REG_SHAPE_WIDTH:  r_cfg.shape_width  <= i_cfg.data[cao_pkg::SIZE_W-1:0];
                cao_pkg::REG_SHAPE_HEIGHT: r_cfg.shape_height <= i_cfg.data[cao_pkg::SIZE_W-1:0];
                cao_pkg::REG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg.data;
                cao_pkg::REG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg.data;
                default:                   r_cfg              <= r_cfg;
            endcase
        end
    end

    // ------------------------------------------------------- pipeline control
    logic r_s1_valid, n_s1_valid;
    logic r_out_valid, n_out_valid;
    logic r_loaded, n_loaded;
    logic s1_move, pix_acc, blend_acc, texel_req, in_range, tex_we;

    assign s1_move     = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_s1_valid || s1_move;
    assign pix_acc     = i_pix.valid && i_pix.ready;
    assign blend_acc   = pix_acc && (i_pix.mode == cao_pkg::MODE_BLEND);
    assign texel_req   = (i_pix.mode == cao_pkg::MODE_COLOR) ||
                         (i_pix.mode == cao_pkg::MODE_MONO);
    // drop texel writes outside the image
    assign in_range    = ({1'b0, i_pix.pos_x} < MAX_POS) && ({1'b0, i_pix.pos_y} < MAX_POS);
    assign tex_we      = pix_acc && texel_req && in_range;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (blend_acc)    n_s1_valid = 1'b1;
        else if (s1_move) n_s1_valid = 1'b0;

        n_out_valid = r_out_valid;
        if (s1_move)          n_out_valid = 1'b1;
        else if (o_res.ready) n_out_valid = 1'b0;

        n_loaded = r_loaded || tex_we;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_loaded    <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            r_loaded    <= n_loaded;
        end
    end

    // ----------------------------------------------------------- texel write
    logic [cao_pkg::TEXEL_W-1:0] texel;

    always_comb begin
        priority if (i_pix.mode == cao_pkg::MODE_COLOR) begin
            texel = {i_pix.alpha, i_pix.red, i_pix.green, i_pix.blue};
        end else if (i_pix.and_bit) begin
            texel = cao_pkg::TEXEL_CLEAR;
        end else if (i_pix.xor_bit) begin
            texel = cao_pkg::TEXEL_WHITE;
        end else begin
            texel = cao_pkg::TEXEL_BLACK;
        end
    end

    // -------------------------------------------------------- window and read
    logic            win_cov;
    logic [2*AW-1:0] win_addr;
    logic [cao_pkg::TEXEL_W-1:0] rd_texel;

    cao_window #(
        .MAX_CURSOR_SIZE (MAX_CURSOR_SIZE),
        .AW              (AW)
    ) u_window (
        .i_cfg     (r_cfg),
        .i_loaded  (r_loaded),
        .i_pos_x   (i_pix.pos_x),
        .i_pos_y   (i_pix.pos_y),
        .o_covered (win_cov),
        .o_addr    (win_addr)
    );

    // Reads issue only on an accepted blend, so the read data holds under stall.
    // A write and a read never share a cycle; a read issued after a write
    // sees the new texel.
    cao_image_store #(
        .ADDR_W (2*AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (tex_we),
        .i_waddr ({i_pix.pos_y[AW-1:0], i_pix.pos_x[AW-1:0]}),
        .i_wdata (texel),
        .i_re    (blend_acc),
        .i_raddr (win_addr),
        .o_rdata (rd_texel)
    );

    // ------------------------------------------------------------ blend stage
    logic          r_s1_cov;
    logic [CW-1:0] r_s1_red, r_s1_green, r_s1_blue;

    always_ff @(posedge i_clk) begin
        if (blend_acc) begin
            r_s1_cov   <= win_cov;
            r_s1_red   <= i_pix.red;
            r_s1_green <= i_pix.green;
            r_s1_blue  <= i_pix.blue;
        end
    end

    logic [CW-1:0] mix_red, mix_green, mix_blue;

    cao_blend u_blend (
        .i_texel   (rd_texel),
        .i_covered (r_s1_cov),
        .i_red     (r_s1_red),
        .i_green   (r_s1_green),
        .i_blue    (r_s1_blue),
        .o_red     (mix_red),
        .o_green   (mix_green),
        .o_blue    (mix_blue)
    );

    // ------------------------------------------------------- output register
    logic          r_out_cov;
    logic [CW-1:0] r_out_red, r_out_green, r_out_blue;

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_cov   <= r_s1_cov;
            r_out_red   <= mix_red;
            r_out_green <= mix_green;
            r_out_blue  <= mix_blue;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_red   = r_out_red;
    assign o_res.out_green = r_out_green;
    assign o_res.out_blue  = r_out_blue;
    assign o_res.covered   = r_out_cov;

`ifndef SYNTH
    // a covered result needs a loaded cursor, and the flag never clears
    a_cov_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cov) |-> r_loaded)
        else $error("covered result without a loaded cursor");

    // an accepted blend request always occupies the blend stage next cycle
    a_blend_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blend_acc |=> r_s1_valid)
        else $error("blend request lost at stage entry");

    // a stalled blend stage keeps its pixel
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> (r_s1_valid && $stable(r_s1_red) &&
                                      $stable(r_s1_cov)))
        else $error("blend stage changed while stalled");

    // an uncovered pixel leaves with its screen red and blue untouched
    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && !r_s1_cov) |=> (o_res.out_red == $past(r_s1_red) &&
                                    o_res.out_blue == $past(r_s1_blue)))
        else $error("uncovered pixel altered");

    // an empty blend stage never blocks the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> i_pix.ready)
        else $error("input stalled with empty blend stage");
`endif

endmodule

// File: sim/tb_cursor_alpha_overlay_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for cursor_alpha_overlay_core: directed rows, then random phases.
// Depends on cao_pkg, cao_if and the core; predicts each blended pixel on its own unless a row types it.
module tb_cursor_alpha_overlay_core;
    import cao_pkg::*;

    localparam int CURSOR_DIM   = 256;
    localparam int DRAIN_CYCLES = 8;      // pipeline depth is two, leave margin
    localparam int HOLD_CYCLES  = 300;    // long receiver stall for back-pressure
    localparam int RAND_ITEMS   = 750;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  alpha;
        logic               and_bit;
        logic               xor_bit;
    } pix_req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              covered;
    } pix_res_t;

    // One row of the directed list: a register write or a pixel request, the
    // latter optionally with a result typed in by hand.
    typedef struct {
        bit                    is_cfg;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
        pix_req_t              req;
        bit                    typed;
        pix_res_t              res;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;

    cao_pix_if pix_if ();
    cao_res_if res_if ();
    cao_cfg_if cfg_if ();

    cursor_alpha_overlay_core #(
        .MAX_CURSOR_SIZE(CURSOR_DIM)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    // Shadow of the block: registers, cursor image and the loaded flag.
    t_cfg             cfg_shadow;
    logic [TEXEL_W-1:0] texel_img     [0:CURSOR_DIM*CURSOR_DIM-1];
    bit               texel_written [0:CURSOR_DIM*CURSOR_DIM-1];
    bit               cursor_present;

    pix_res_t pixel_expect_q[$];

    int n_writes, n_blends, n_covered, n_ignored, n_cfg, n_checked, n_errors;
    int n_holds, n_phases;
    bit tx_burst, rx_burst, hold_req;

    // Free-running 10 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops a result.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int clamp_size(input logic [SIZE_W-1:0] s);
        int v;
        v = s;
        if (v < 1) v = 1;
        if (v > CURSOR_DIM) v = CURSOR_DIM;
        return v;
    endfunction

    // Effective cursor size and the screen position of its top-left texel.
    function automatic void window_geom(output int w, output int h,
                                        output int ox, output int oy);
        int hx, hy;
        w  = clamp_size(cfg_shadow.shape_width);
        h  = clamp_size(cfg_shadow.shape_height);
        hx = cfg_shadow.hotspot_x;
        hy = cfg_shadow.hotspot_y;
        if (hx > w) hx = w - 1;
        if (hy > h) hy = h - 1;
        ox = int'(cfg_shadow.pointer_x) - hx;
        oy = int'(cfg_shadow.pointer_y) - hy;
    endfunction

    // Image index under a screen pixel, or -1 when the pixel is not covered.
    function automatic int cover_index(input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y);
        int w, h, ox, oy, dx, dy;
        window_geom(w, h, ox, oy);
        dx = int'(x) - ox;
        dy = int'(y) - oy;
        if (!cursor_present || x >= cfg_shadow.frame_width || y >= cfg_shadow.frame_height)
            return -1;
        if (dx < 0 || dx >= w || dy < 0 || dy >= h)
            return -1;
        return dy * CURSOR_DIM + dx;
    endfunction

    function automatic logic [CHAN_W-1:0] blend_channel(input logic [CHAN_W-1:0] old_c,
                                                        input logic [CHAN_W-1:0] new_c,
                                                        input logic [CHAN_W-1:0] a);
        int o, n, al, s;
        o  = old_c;
        n  = new_c;
        al = a;
        s  = o * (256 - al) + n * al;
        return s[15:8];
    endfunction

    // Advance the shadow by one accepted request; queue the pixel it yields.
    function automatic void apply_request(input pix_req_t q, input bit typed,
                                          input pix_res_t tres);
        pix_res_t           p;
        int                 idx;
        logic [TEXEL_W-1:0] t;
        case (q.mode)
            MODE_COLOR, MODE_MONO: begin
                if (q.pos_x >= CURSOR_DIM || q.pos_y >= CURSOR_DIM) begin
                    n_ignored++;
                end else begin
                    if (q.mode == MODE_COLOR)
                        t = {q.alpha, q.red, q.green, q.blue};
                    else if (q.and_bit)
                        t = TEXEL_CLEAR;
                    else if (q.xor_bit)
                        t = TEXEL_WHITE;
                    else
                        t = TEXEL_BLACK;
                    idx = int'(q.pos_y) * CURSOR_DIM + int'(q.pos_x);
                    texel_img[idx]     = t;
                    texel_written[idx] = 1'b1;
                    cursor_present     = 1'b1;
                    n_writes++;
                end
            end
            MODE_BLEND: begin
                idx = cover_index(q.pos_x, q.pos_y);
                p   = '{red: q.red, green: q.green, blue: q.blue, covered: 1'b0};
                if (idx >= 0) begin
                    t         = texel_img[idx];
                    p.red     = blend_channel(q.red,   t[23:16], t[31:24]);
                    p.green   = blend_channel(q.green, t[15:8],  t[31:24]);
                    p.blue    = blend_channel(q.blue,  t[7:0],   t[31:24]);
                    p.covered = 1'b1;
                    n_covered++;
                end
                n_blends++;
                pixel_expect_q.push_back(typed ? tres : p);
            end
            default: n_ignored++;
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic pix_req_t texel_req(input int x, input int y);
        pix_req_t q;
        q.mode    = ($urandom_range(0, 1) == 0) ? MODE_COLOR : MODE_MONO;
        q.pos_x   = x;
        q.pos_y   = y;
        q.red     = pick_level();
        q.green   = pick_level();
        q.blue    = pick_level();
        q.alpha   = pick_level();
        q.and_bit = $urandom_range(0, 1);
        q.xor_bit = $urandom_range(0, 1);
        return q;
    endfunction

    function automatic pix_req_t blend_req(input int x, input int y);
        pix_req_t q;
        q      = texel_req(0, 0);
        q.mode = MODE_BLEND;
        q.pos_x = x;
        q.pos_y = y;
        return q;
    endfunction

    // Coordinate around the window on one axis, two pixels of margin each side.
    function automatic int near_coord(input int org, input int size);
        int v;
        v = org - 2 + $urandom_range(0, size + 3);
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v;
    endfunction

    function automatic stim_row_t cfg_row(input t_cfg_idx idx, input int data);
        stim_row_t r;
        r        = '{idx: REG_POINTER_X, default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic stim_row_t px_row(input logic [MODE_W-1:0] mode, input int x, input int y,
                                         input int red, input int green, input int blue,
                                         input int alpha, input bit ab, input bit xb);
        stim_row_t r;
        r     = '{idx: REG_POINTER_X, default: '0};
        r.req = '{mode: mode, pos_x: x, pos_y: y, red: red, green: green, blue: blue,
                  alpha: alpha, and_bit: ab, xor_bit: xb};
        return r;
    endfunction

    function automatic stim_row_t with_result(input stim_row_t r, input int red, input int green,
                                              input int blue, input bit cov);
        r.typed = 1'b1;
        r.res   = '{red: red, green: green, blue: blue, covered: cov};
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [CHAN_W-1:0] exp_v,
                                        input logic [CHAN_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // Offer one request after a random gap; hold it until accepted.
    // Called and returning at a falling edge.
    task automatic send_request(input pix_req_t req, input bit typed, input pix_res_t tres);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_if.valid   <= 1'b1;
        pix_if.mode    <= req.mode;
        pix_if.pos_x   <= req.pos_x;
        pix_if.pos_y   <= req.pos_y;
        pix_if.red     <= req.red;
        pix_if.green   <= req.green;
        pix_if.blue    <= req.blue;
        pix_if.alpha   <= req.alpha;
        pix_if.and_bit <= req.and_bit;
        pix_if.xor_bit <= req.xor_bit;
        do @(posedge i_clk); while (pix_if.ready !== 1'b1);
        apply_request(req, typed, tres);
        @(negedge i_clk);
    endtask

    // Never blend over a texel that was never written: load it first.
    task automatic send_pixel(input pix_req_t req, input bit typed, input pix_res_t tres);
        int idx;
        if (req.mode == MODE_BLEND) begin
            idx = cover_index(req.pos_x, req.pos_y);
            if (idx >= 0 && !texel_written[idx])
                send_request(texel_req(idx % CURSOR_DIM, idx / CURSOR_DIM), 1'b0, tres);
        end
        send_request(req, typed, tres);
    endtask

    // Write one register with the pixel path drained and quiet.
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        pix_if.valid <= 1'b0;
        while (pixel_expect_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            REG_POINTER_X:    cfg_shadow.pointer_x    = data;
            REG_POINTER_Y:    cfg_shadow.pointer_y    = data;
            REG_HOTSPOT_X:    cfg_shadow.hotspot_x    = data[HOT_W-1:0];
            REG_HOTSPOT_Y:    cfg_shadow.hotspot_y    = data[HOT_W-1:0];
            REG_SHAPE_WIDTH:  cfg_shadow.shape_width  = data[SIZE_W-1:0];
            REG_SHAPE_HEIGHT: cfg_shadow.shape_height = data[SIZE_W-1:0];
            REG_FRAME_WIDTH:  cfg_shadow.frame_width  = data;
            REG_FRAME_HEIGHT: cfg_shadow.frame_height = data;
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Receiver: take results at the rising edge, compare with the oldest
    // prediction, then stall for a drawn number of cycles.
    initial begin
        pix_res_t exp_r;
        int       gap;
        res_if.ready = 1'b0;
        rx_burst     = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        res_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1) begin
                if (pixel_expect_q.size() == 0) begin
                    $display("%0t ns: result with none expected, actual %h %h %h covered %b",
                             $time, res_if.out_red, res_if.out_green, res_if.out_blue,
                             res_if.covered);
                    n_errors++;
                end else begin
                    exp_r = pixel_expect_q.pop_front();
                    check_field("out_red",   exp_r.red,   res_if.out_red);
                    check_field("out_green", exp_r.green, res_if.out_green);
                    check_field("out_blue",  exp_r.blue,  res_if.out_blue);
                    check_field("covered",   {7'd0, exp_r.covered}, {7'd0, res_if.covered});
                end
                n_checked++;
                if (n_checked % 40 == 0)
                    rx_burst = ($urandom_range(0, 3) == 0);
                @(negedge i_clk);
                gap = rx_burst ? 0 : $urandom_range(0, 11);
                // Hold off for a long stretch on request so the pipeline fills.
                if (hold_req) begin
                    hold_req = 1'b0;
                    gap      = HOLD_CYCLES;
                    n_holds++;
                end
                if (gap > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                    res_if.ready <= 1'b1;
                end
            end
        end
    end

    // Main sequence: reset, directed rows, random phases, drain and verdict.
    initial begin
        stim_row_t             dir_rows[$];
        pix_req_t              q;
        pix_res_t              no_res;
        logic [CFG_DATA_W-1:0] d;
        int                    sw, sh, hxv, hyv, w, h, ox, oy, n, pick;

        // Drive every input to a known value before the first edge.
        i_rst_n        = 1'b0;
        pix_if.valid   = 1'b0;
        pix_if.mode    = MODE_COLOR;
        pix_if.pos_x   = '0;
        pix_if.pos_y   = '0;
        pix_if.red     = '0;
        pix_if.green   = '0;
        pix_if.blue    = '0;
        pix_if.alpha   = '0;
        pix_if.and_bit = 1'b0;
        pix_if.xor_bit = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = REG_POINTER_X;
        cfg_if.data    = '0;
        no_res         = '0;
        hold_req       = 1'b0;
        tx_burst       = 1'b0;
        cfg_shadow              = '0;
        cfg_shadow.shape_width  = SHAPE_RESET;
        cfg_shadow.shape_height = SHAPE_RESET;
        cursor_present          = 1'b0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows. No cursor yet: pixels pass through uncovered.
        dir_rows.push_back(with_result(px_row(MODE_BLEND, 0, 0, 'hFF, 'h00, 'hFF, 0, 0, 0),
                                       'hFF, 'h00, 'hFF, 0));
        dir_rows.push_back(px_row(MODE_UNUSED, 'hFFFF, 'hFFFF, 'hFF, 'hFF, 'hFF, 'hFF, 1, 1));
        dir_rows.push_back(with_result(px_row(MODE_BLEND, 'hFFFF, 'hFFFF, 0, 'hFF, 0, 'hFF, 1, 1),
                                       'h00, 'hFF, 'h00, 0));
        // 2x2 cursor at (10,20), hotspot at its corner.
        dir_rows.push_back(cfg_row(REG_FRAME_WIDTH, 640));
        dir_rows.push_back(cfg_row(REG_FRAME_HEIGHT, 480));
        dir_rows.push_back(cfg_row(REG_POINTER_X, 10));
        dir_rows.push_back(cfg_row(REG_POINTER_Y, 20));
        dir_rows.push_back(cfg_row(REG_SHAPE_WIDTH, 2));
        dir_rows.push_back(cfg_row(REG_SHAPE_HEIGHT, 2));
        // Load: transparent, white, black and one half-opaque colour texel.
        dir_rows.push_back(px_row(MODE_MONO, 0, 0, 0, 0, 0, 0, 1, 1));
        dir_rows.push_back(px_row(MODE_MONO, 1, 0, 0, 0, 0, 0, 0, 1));
        dir_rows.push_back(px_row(MODE_MONO, 0, 1, 'hFF, 'hFF, 'hFF, 'hFF, 0, 0));
        dir_rows.push_back(px_row(MODE_COLOR, 1, 1, 'h40, 'hC0, 'hFF, 'h80, 1, 0));
        // Texel positions past the image are dropped.
        dir_rows.push_back(px_row(MODE_COLOR, 256, 0, 'hFF, 'hFF, 'hFF, 'hFF, 0, 0));
        dir_rows.push_back(px_row(MODE_MONO, 0, 'hFFFF, 0, 0, 0, 0, 0, 1));
        dir_rows.push_back(with_result(px_row(MODE_BLEND, 10, 20, 'h12, 'h34, 'h56, 0, 0, 0),
                                       'h12, 'h34, 'h56, 1));
        dir_rows.push_back(px_row(MODE_BLEND, 11, 20, 'h00, 'h00, 'h00, 0, 0, 0));
        dir_rows.push_back(px_row(MODE_BLEND, 10, 21, 'hFF, 'hFF, 'hFF, 0, 0, 0));
        dir_rows.push_back(px_row(MODE_BLEND, 11, 21, 'h10, 'h20, 'h30, 0, 0, 0));
        dir_rows.push_back(with_result(px_row(MODE_BLEND, 12, 20, 1, 2, 3, 0, 0, 0), 1, 2, 3, 0));
        dir_rows.push_back(with_result(px_row(MODE_BLEND, 10, 22, 4, 5, 6, 0, 0, 0), 4, 5, 6, 0));
        dir_rows.push_back(with_result(px_row(MODE_BLEND, 9, 19, 7, 8, 9, 0, 0, 0), 7, 8, 9, 0));
        // Hotspot past the width clamps to one less; equal to the height stays.
        dir_rows.push_back(cfg_row(REG_HOTSPOT_X, 255));
        dir_rows.push_back(cfg_row(REG_HOTSPOT_Y, 2));
        dir_rows.push_back(with_result(px_row(MODE_BLEND, 9, 18, 'hA0, 'hB0, 'hC0, 0, 0, 0),
                                       'hA0, 'hB0, 'hC0, 1));
        dir_rows.push_back(px_row(MODE_BLEND, 10, 19, 'h55, 'hAA, 'h55, 0, 0, 0));
        dir_rows.push_back(with_result(px_row(MODE_BLEND, 10, 20, 9, 9, 9, 0, 0, 0), 9, 9, 9, 0));
        // Pixel beyond the frame passes through.
        dir_rows.push_back(cfg_row(REG_FRAME_WIDTH, 10));
        dir_rows.push_back(with_result(px_row(MODE_BLEND, 10, 19, 3, 3, 3, 0, 0, 0), 3, 3, 3, 0));
        // Window hanging off the top-left corner of the frame.
        dir_rows.push_back(cfg_row(REG_FRAME_WIDTH, 640));
        dir_rows.push_back(cfg_row(REG_POINTER_X, 0));
        dir_rows.push_back(cfg_row(REG_POINTER_Y, 0));
        dir_rows.push_back(cfg_row(REG_HOTSPOT_Y, 1));
        dir_rows.push_back(px_row(MODE_BLEND, 0, 0, 'h80, 'h80, 'h80, 0, 0, 0));
        dir_rows.push_back(with_result(px_row(MODE_BLEND, 1, 0, 6, 6, 6, 0, 0, 0), 6, 6, 6, 0));
        // Zero width is taken as one; the x hotspot clamps to zero.
        dir_rows.push_back(cfg_row(REG_SHAPE_WIDTH, 0));
        dir_rows.push_back(px_row(MODE_BLEND, 0, 0, 'h11, 'h22, 'h33, 0, 0, 0));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg)
                cfg_write(dir_rows[i].idx, dir_rows[i].data);
            else
                send_pixel(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        end

        // Random phases: program all registers, load small shapes most of the time, then either
        // blends under back-pressure or a mix of blends around the window, noise writes and drops.
        while (n_writes + n_blends < RAND_ITEMS + 25) begin
            case (n_phases % 8)
                1:       begin sw = 0; sh = 0; end
                2:       begin sw = 511; sh = $urandom_range(1, 3); end
                4:       begin sw = $urandom_range(1, 4); sh = 256; end
                5:       begin sw = $urandom_range(0, 511); sh = $urandom_range(0, 511); end
                default: begin sw = $urandom_range(1, 8); sh = $urandom_range(1, 8); end
            endcase
            d = $urandom_range(0, 65535); d[SIZE_W-1:0] = sw; cfg_write(REG_SHAPE_WIDTH, d);
            d = $urandom_range(0, 65535); d[SIZE_W-1:0] = sh; cfg_write(REG_SHAPE_HEIGHT, d);
            case ($urandom_range(0, 3))
                0:       begin hxv = 0;   hyv = 0;   end
                1:       begin hxv = 255; hyv = 255; end
                default: begin
                    hxv = $urandom_range(0, (clamp_size(sw) > 255) ? 255 : clamp_size(sw));
                    hyv = $urandom_range(0, (clamp_size(sh) > 255) ? 255 : clamp_size(sh));
                end
            endcase
            d = $urandom_range(0, 65535); d[HOT_W-1:0] = hxv; cfg_write(REG_HOTSPOT_X, d);
            d = $urandom_range(0, 65535); d[HOT_W-1:0] = hyv; cfg_write(REG_HOTSPOT_Y, d);
            case ($urandom_range(0, 4))
                0:       d = 16'h0000;
                1:       d = 16'hFFFF;
                2:       d = $urandom_range(0, 4);
                default: d = $urandom_range(0, 65535);
            endcase
            cfg_write(REG_POINTER_X, d);
            cfg_write(REG_POINTER_Y, ($urandom_range(0, 1) == 0) ? d : $urandom_range(0, 65535));
            case ($urandom_range(0, 4))
                0:       d = 16'h0000;
                1:       d = 16'hFFFF;
                2:       d = (cfg_shadow.pointer_x > 65532) ? 16'hFFFF
                                                            : cfg_shadow.pointer_x + 3;
                default: d = $urandom_range(0, 65535);
            endcase
            cfg_write(REG_FRAME_WIDTH, d);
            cfg_write(REG_FRAME_HEIGHT, ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                        : ((cfg_shadow.pointer_y > 65532) ? 16'hFFFF
                                           : cfg_shadow.pointer_y + $urandom_range(0, 3)));
            n_phases++;
            tx_burst = ($urandom_range(0, 3) == 0);
            window_geom(w, h, ox, oy);

            // Load the whole shape when it is small, three times in four; others fill on demand.
            if (w * h <= 64 && $urandom_range(0, 3) != 0) begin
                for (int ty = 0; ty < h; ty++)
                    for (int tx = 0; tx < w; tx++)
                        send_pixel(texel_req(tx, ty), 1'b0, no_res);
            end

            if (n_phases % 8 == 4) begin
                // Back-pressure phase: stream blends while the receiver holds off.
                tx_burst = 1'b1;
                hold_req = 1'b1;
                repeat (60)
                    send_pixel(blend_req(near_coord(ox, w), near_coord(oy, h)), 1'b0, no_res);
            end else begin
                n = $urandom_range(30, 70);
                repeat (n) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70) begin
                        q = blend_req(near_coord(ox, w), near_coord(oy, h));
                    end else if (pick < 80) begin
                        q = blend_req($urandom_range(0, 65535), $urandom_range(0, 65535));
                    end else if (pick < 90) begin
                        q = texel_req($urandom_range(0, w - 1), $urandom_range(0, h - 1));
                    end else if (pick < 95) begin
                        // Texel position past the image: dropped.
                        q = texel_req($urandom_range(0, 65535), $urandom_range(0, 65535));
                        if ($urandom_range(0, 1) == 0)
                            q.pos_x = $urandom_range(CURSOR_DIM, 65535);
                        else
                            q.pos_y = $urandom_range(CURSOR_DIM, 65535);
                    end else begin
                        q      = blend_req($urandom_range(0, 65535), $urandom_range(0, 65535));
                        q.mode = MODE_UNUSED;
                    end
                    send_pixel(q, 1'b0, no_res);
                end
            end
        end

        // Drain: drop valid, wait for every expected pixel, then linger.
        pix_if.valid <= 1'b0;
        while (pixel_expect_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d texel writes, %0d screen pixels (%0d under the cursor),",
                 n_writes, n_blends, n_covered);
        $display("%0d dropped requests, %0d register writes over %0d random phases,",
                 n_ignored, n_cfg, n_phases);
        $display("%0d long receiver hold(s), %0d errors", n_holds, n_errors);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
